// ===== rtl/lcsr_pkg.sv =====
// lcsr_pkg: shared types and constants of the load-cell serial reader
// no dependencies; used by the channel interfaces, the divider and the top level

package lcsr_pkg;

  // field widths fixed by the item formats
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned SCALE_W   = 24;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned WEIGHT_W  = 25;
  localparam int unsigned BIT_IDX_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 24;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WEIGH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TARE  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd1;

  // register reset values
  localparam logic [SCALE_W-1:0] SCALE_RESET   = 24'd102400;
  localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd2000;

  // result kinds
  localparam logic KIND_WEIGHT = 1'b0;
  localparam logic KIND_TARE   = 1'b1;

  // largest weight magnitude
  localparam logic [SCALE_W-1:0] WEIGHT_MAX = 24'hFFFFFF;

  // read sequence phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_WAIT = 5'b00010,
    PH_LOW  = 5'b00100,
    PH_HIGH = 5'b01000,
    PH_DONE = 5'b10000
  } phase_e;

  // divider status toward the top level
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/lcsr_if.sv =====
// lcsr_if: valid/ready channel interfaces for input items, result items and config writes
// depends on lcsr_pkg for field widths

interface lcsr_in_if import lcsr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic             data_pin;

  modport source (output valid, command, data_pin, input ready);
  modport sink   (input valid, command, data_pin, output ready);
endinterface

interface lcsr_out_if import lcsr_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       clock_pin;
  logic                       result_valid;
  logic                       result_kind;
  logic signed [WEIGHT_W-1:0] weight;
  logic                       timed_out;
  logic                       busy_res;

  modport source (output valid, clock_pin, result_valid, result_kind, weight, timed_out,
                  busy_res, input ready);
  modport sink   (input valid, clock_pin, result_valid, result_kind, weight, timed_out,
                  busy_res, output ready);
endinterface

interface lcsr_cfg_if import lcsr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/lcsr_div.sv =====
// lcsr_div: bit-serial restoring divider, one quotient bit per cycle, saturating result
// depends on lcsr_pkg for widths and the weight limit

module lcsr_div import lcsr_pkg::*; #(
  parameter int unsigned DVD_W = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DVD_W-1:0]   dividend_i,
  input  logic [SCALE_W-1:0] divisor_i,
  output div_stat_t          stat_o,
  output logic [SCALE_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DVD_W);

  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [SCALE_W:0]   rem_q, rem_d;
  logic [DVD_W-1:0]   quo_q, quo_d;
  logic [SCALE_W:0]   rem_sh;
  logic               ge;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem_q[SCALE_W-1:0], quo_q[DVD_W-1]};
    ge     = rem_sh >= {1'b0, divisor_i};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d = CNT_LOAD;
      rem_d = '0;
      quo_d = dividend_i;
    end else if (cnt_q != '0) begin
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
      rem_d  = ge ? (rem_sh - {1'b0, divisor_i}) : rem_sh;
      quo_d  = {quo_q[DVD_W-2:0], ge};
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  // saturate quotients beyond the weight range
  assign quotient_o  = (|quo_q[DVD_W-1:SCALE_W]) ? WEIGHT_MAX : quo_q[SCALE_W-1:0];
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

// ===== rtl/load_cell_serial_reader_tare_scale_core.sv =====
// load_cell_serial_reader_tare_scale_core: one timebase tick per input item, one result item each.
// Most items give their result in the cycle after acceptance; one item per cycle when drained.
// The finishing tick of a weigh read that differs from the tare runs the bit-serial divider:
// SAMPLE_BITS+8 quotient bits (at least 25), one per cycle, before its result is released.
// No item is taken while a division is running; config is always ready.
// Reset: idle phase, tare 0, scale 102400 (400.0 in Q.8), timeout 2000 ticks, no result pending.

module load_cell_serial_reader_tare_scale_core import lcsr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lcsr_in_if.sink    in_if,
  lcsr_out_if.source out_if,
  lcsr_cfg_if.sink   cfg_if
);

  localparam int unsigned DVD_W =
    (SAMPLE_BITS + 8 > WEIGHT_W) ? SAMPLE_BITS + 8 : WEIGHT_W;
  localparam logic [BIT_IDX_W:0] BIT_LIMIT = (BIT_IDX_W + 1)'(SAMPLE_BITS);
  localparam logic [SAMPLE_BITS-1:0] MSB_FLIP = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // configuration registers
  logic [SCALE_W-1:0] scale_q;
  logic [TMO_W-1:0]   timeout_q;

  // read sequence state
  phase_e                 phase_q, phase_d;
  logic [BIT_IDX_W-1:0]   bit_q, bit_d;
  logic [SAMPLE_BITS-1:0] shift_q, shift_d;
  logic [TMO_W-1:0]       wait_q, wait_d;
  logic [SAMPLE_BITS-1:0] tare_q, tare_d;
  logic                   is_tare_q, is_tare_d;
  logic                   tmo_seen_q, tmo_seen_d;

  // result register
  logic                       out_valid_q, out_valid_d;
  logic                       clk_pin_q, clk_pin_d;
  logic                       res_valid_q, res_valid_d;
  logic                       kind_q, kind_d;
  logic signed [WEIGHT_W-1:0] weight_q, weight_d;
  logic                       tmo_out_q, tmo_out_d;
  logic                       busy_q, busy_d;

  // division bookkeeping
  logic                   div_pend_q, div_pend_d;
  logic                   neg_q, neg_d;
  logic                   div_start;
  div_stat_t              div_stat;
  logic [SCALE_W-1:0]     div_quo;
  logic [SAMPLE_BITS-1:0] word;
  logic                   word_neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [DVD_W-1:0]       dividend;

  logic in_acc;
  logic out_take;

  assign in_if.ready  = !div_pend_q && (!out_valid_q || out_if.ready);
  assign cfg_if.ready = 1'b1;
  assign in_acc       = in_if.valid && in_if.ready;
  assign out_take     = out_valid_q && out_if.ready;

  // finished word and its distance from the tare
  assign word     = shift_q ^ MSB_FLIP;
  assign word_neg = word < tare_q;
  assign mag      = word_neg ? (tare_q - word) : (word - tare_q);
  assign dividend = DVD_W'({mag, 8'h00});

  // tick sequencer and result loading
  always_comb begin
    phase_d     = phase_q;
    bit_d       = bit_q;
    shift_d     = shift_q;
    wait_d      = wait_q;
    tare_d      = tare_q;
    is_tare_d   = is_tare_q;
    tmo_seen_d  = tmo_seen_q;
    out_valid_d = out_valid_q;
    clk_pin_d   = clk_pin_q;
    res_valid_d = res_valid_q;
    kind_d      = kind_q;
    weight_d    = weight_q;
    tmo_out_d   = tmo_out_q;
    busy_d      = busy_q;
    div_pend_d  = div_pend_q;
    neg_d       = neg_q;
    div_start   = 1'b0;

    if (out_take) begin
      out_valid_d = 1'b0;
    end

    if (in_acc) begin
      clk_pin_d   = 1'b0;
      res_valid_d = 1'b0;
      kind_d      = KIND_WEIGHT;
      weight_d    = '0;
      tmo_out_d   = 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          if (in_if.command == CMD_WEIGH || in_if.command == CMD_TARE) begin
            is_tare_d  = (in_if.command == CMD_TARE);
            shift_d    = '0;
            bit_d      = '0;
            wait_d     = '0;
            tmo_seen_d = 1'b0;
            phase_d    = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (!in_if.data_pin) begin
            clk_pin_d = 1'b1;
            phase_d   = PH_LOW;
          end else begin
            wait_d = wait_q + 1'b1;
            if (wait_d >= timeout_q) begin
              tmo_seen_d = 1'b1;
              clk_pin_d  = 1'b1;
              phase_d    = PH_LOW;
            end
          end
        end
        PH_LOW: begin
          shift_d = {shift_q[SAMPLE_BITS-2:0], in_if.data_pin};
          bit_d   = bit_q + 1'b1;
          phase_d = PH_HIGH;
        end
        PH_HIGH: begin
          clk_pin_d = 1'b1;
          phase_d   = (({1'b0, bit_q} >= BIT_LIMIT) || (bit_q == '0)) ? PH_DONE : PH_LOW;
        end
        PH_DONE: begin
          shift_d     = word;
          res_valid_d = 1'b1;
          tmo_out_d   = tmo_seen_q;
          if (is_tare_q) begin
            tare_d = word;
            kind_d = KIND_TARE;
          end else if (mag != '0) begin
            div_start = 1'b1;
            neg_d     = word_neg;
          end
          phase_d = PH_IDLE;
        end
        default: phase_d = PH_IDLE;
      endcase
      busy_d      = (phase_d != PH_IDLE);
      out_valid_d = !div_start;
      div_pend_d  = div_start;
    end

    // quotient arrives: sign it and release the result
    if (div_stat.done) begin
      weight_d    = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      out_valid_d = 1'b1;
      div_pend_d  = 1'b0;
    end
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q     <= SCALE_RESET;
      timeout_q   <= TIMEOUT_RESET;
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      shift_q     <= '0;
      wait_q      <= '0;
      tare_q      <= '0;
      is_tare_q   <= 1'b0;
      tmo_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
      div_pend_q  <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        unique case (cfg_if.index)
          CFG_SCALE:   scale_q   <= cfg_if.data[SCALE_W-1:0];
          CFG_TIMEOUT: timeout_q <= cfg_if.data[TMO_W-1:0];
          default: ;
        endcase
      end
      phase_q     <= phase_d;
      bit_q       <= bit_d;
      shift_q     <= shift_d;
      wait_q      <= wait_d;
      tare_q      <= tare_d;
      is_tare_q   <= is_tare_d;
      tmo_seen_q  <= tmo_seen_d;
      out_valid_q <= out_valid_d;
      div_pend_q  <= div_pend_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    clk_pin_q   <= clk_pin_d;
    res_valid_q <= res_valid_d;
    kind_q      <= kind_d;
    weight_q    <= weight_d;
    tmo_out_q   <= tmo_out_d;
    busy_q      <= busy_d;
    neg_q       <= neg_d;
  end

  // serial divider for the scaled weight
  lcsr_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (scale_q),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  assign out_if.valid        = out_valid_q;
  assign out_if.clock_pin    = clk_pin_q;
  assign out_if.result_valid = res_valid_q;
  assign out_if.result_kind  = kind_q;
  assign out_if.weight       = weight_q;
  assign out_if.timed_out    = tmo_out_q;
  assign out_if.busy_res     = busy_q;

  // divider only starts when idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy && !div_pend_q)
    else $error("divider started while busy");

  // no result shown and no input taken while a division is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_pend_q |-> !out_if.valid && !in_if.ready)
    else $error("result or input open during division");

  // a finished division releases its result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |=> out_if.valid && !div_pend_q)
    else $error("quotient not released");

  // divider runs only for a pending weigh result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> div_pend_q)
    else $error("divider busy without pending result");

endmodule
